// ===== rtl/tropical_determinant_hungarian_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tropical determinant block
// Clock is clk, reset is arst_n (active low) at every use site.
// ----------------------------------------------------------------------------
`ifndef TROPICAL_DETERMINANT_HUNGARIAN_TOP_MACROS_SVH
`define TROPICAL_DETERMINANT_HUNGARIAN_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define TDH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define TDH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define TDH_ASSERT_NOW(lbl, ante, cons)
`define TDH_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/tdh_pkg.sv =====
// ----------------------------------------------------------------------------
// tdh_pkg
// Shared widths, markers and types of the tropical determinant block.
// ----------------------------------------------------------------------------
package tdh_pkg;

	localparam int MAX_SIZE = 16;
	localparam int IW = 4;                 // row / column index
	localparam int CW = 5;                 // count or index with none marker
	localparam int VW = 16;                // entry value
	localparam int LW = 21;                // labels
	localparam int SW = 23;                // slack
	localparam int DW = 20;                // determinant
	localparam int AW = 2 * IW;            // matrix store address
	localparam logic [CW-1:0] NONE_MARK = '1;

	typedef struct packed {
		logic                 tight;  // usable edge with zero slack
		logic                 take;   // slack beats the running best, or no best is found yet
		logic signed [SW-1:0] slack;
	} slack_t;

endpackage

// ===== rtl/tdh_ram.sv =====
// ----------------------------------------------------------------------------
// tdh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdh_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tdh_slack.sv =====
// ----------------------------------------------------------------------------
// tdh_slack
// Shared slack unit: slack = w - row_label - col_label, tight test and
// running-maximum compare.
// ----------------------------------------------------------------------------
module tdh_slack (
	input  logic signed [tdh_pkg::VW-1:0] value,
	input  logic                          usable,
	input  logic signed [tdh_pkg::LW-1:0] row_label,
	input  logic signed [tdh_pkg::LW-1:0] col_label,
	input  logic                          found,
	input  logic signed [tdh_pkg::SW-1:0] best,
	output tdh_pkg::slack_t               res
);

	logic signed [tdh_pkg::SW-1:0] s;

	always_comb begin
		s = tdh_pkg::SW'(value) - tdh_pkg::SW'(row_label) - tdh_pkg::SW'(col_label);
		res.slack = s;
		res.tight = usable && (s == '0);
		res.take  = usable && (!found || (s > best));
	end

endmodule

// ===== rtl/tropical_determinant_hungarian_top.sv =====
// ----------------------------------------------------------------------------
// tropical_determinant_hungarian_top
// Max-plus determinant of a loaded matrix by the Hungarian method.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_we/cfg_index/cfg_data set row_count (0) and col_count (1), 5 bits
//    each, saturated at 16. Write only while idle.
//  - The slave stream loads one entry per transfer, one per cycle while
//    loading. tlast marks the final entry and starts the computation; the
//    port then drops tready until the result is placed in the output register.
//  - Every matrix entry is read from a store with one registered read port,
//    so each read takes a read state and a use state. With n = max(rows,
//    cols): setup, the column-maximum pass, then per phase the tree search
//    passes, label updates and the augmentation, then the final sum and the
//    handoff to the output. A phase runs at most 2n+1 searches.
//  - The master stream carries one result per tlast; a stalled result waits
//    in the output register while new entries are already loaded.
//  - Reset sets both counts to 16 and empties the output; stored matrix
//    entries are undefined until written.
// ----------------------------------------------------------------------------
`include "tropical_determinant_hungarian_top_macros.svh"

module tropical_determinant_hungarian_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // entry_row[3:0], entry_col[7:4], entry_value[23:8]
	input  logic        s_tuser,   // entry_is_minus_inf
	input  logic        s_tlast,   // last_entry
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // determinant[19:0], zero fill [23:20]
	output logic        m_tuser,   // det_is_minus_inf
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int N = tdh_pkg::MAX_SIZE;
	localparam int IW = tdh_pkg::IW;
	localparam int CW = tdh_pkg::CW;
	localparam int VW = tdh_pkg::VW;
	localparam int LW = tdh_pkg::LW;
	localparam int SW = tdh_pkg::SW;
	localparam int DW = tdh_pkg::DW;
	localparam int AW = tdh_pkg::AW;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_SETUP    = 4'd1;
	localparam logic [3:0] ST_CMAX_RD  = 4'd2;
	localparam logic [3:0] ST_CMAX_USE = 4'd3;
	localparam logic [3:0] ST_PHASE    = 4'd4;
	localparam logic [3:0] ST_SCAN_RD  = 4'd5;
	localparam logic [3:0] ST_SCAN_USE = 4'd6;
	localparam logic [3:0] ST_ADJ      = 4'd7;
	localparam logic [3:0] ST_GROW     = 4'd8;
	localparam logic [3:0] ST_AUG      = 4'd9;
	localparam logic [3:0] ST_SUM_RD   = 4'd10;
	localparam logic [3:0] ST_SUM_USE  = 4'd11;
	localparam logic [3:0] ST_OUT      = 4'd12;

	localparam logic [CW-1:0] SIZE_MAX = CW'(N);

	logic [3:0]    state_q;
	logic [CW-1:0] cfg_row_q, cfg_col_q;
	logic [CW-1:0] n_q, m_q, matched_q;
	logic          trans_q;
	logic [IW-1:0] ri_q, cj_q, par_q, root_q;
	logic          found_q;
	logic signed [SW-1:0] best_q;
	logic signed [DW-1:0] sum_q;
	logic signed [DW-1:0] res_det_q;
	logic          res_inf_q;
	logic          out_valid_q;
	logic [DW-1:0] out_det_q;
	logic          out_inf_q;

	logic signed [LW-1:0] rl_q [N];
	logic signed [LW-1:0] cl_q [N];
	logic [CW-1:0] roc_q  [N];
	logic [CW-1:0] cor_q  [N];
	logic [CW-1:0] rpar_q [N];
	logic [CW-1:0] cpar_q [N];
	logic [N-1:0]  rtree_q, ctree_q;

	// ------------------------------------------------------------------
	// sizes
	logic [CW-1:0] r_eff, c_eff, n_nxt;
	logic [CW-1:0] nm1;
	logic          last_r, last_c;

	always_comb begin
		r_eff = (cfg_row_q > SIZE_MAX) ? SIZE_MAX : cfg_row_q;
		c_eff = (cfg_col_q > SIZE_MAX) ? SIZE_MAX : cfg_col_q;
		n_nxt = (r_eff > c_eff) ? r_eff : c_eff;
		nm1   = n_q - CW'(1);
		last_r = ({1'b0, ri_q} == nm1);
		last_c = ({1'b0, cj_q} == nm1);
	end

	// ------------------------------------------------------------------
	// matrix store
	logic          accept_in;
	logic [IW-1:0] rd_row;
	logic [AW-1:0] raddr;
	logic [VW:0]   rdata;
	logic [VW:0]   wdata;

	assign s_tready  = (state_q == ST_LOAD);
	assign accept_in = s_tvalid && s_tready;
	assign wdata     = s_tuser ? {1'b1, {VW{1'b0}}} : {1'b0, s_tdata[23:8]};
	assign rd_row    = (state_q == ST_SUM_RD) ? roc_q[cj_q][IW-1:0] : ri_q;
	assign raddr     = trans_q ? {cj_q, rd_row} : {rd_row, cj_q};

	tdh_ram #(
		.WIDTH(VW + 1),
		.DEPTH(N * N)
	) u_store (
		.clk  (clk),
		.we   (accept_in),
		.waddr({s_tdata[3:0], s_tdata[7:4]}),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// padded rows read as finite zero
	logic                 pad, e_inf;
	logic signed [VW-1:0] e_val;

	always_comb begin
		pad   = ({1'b0, ri_q} >= m_q);
		e_inf = !pad && rdata[VW];
		e_val = pad ? '0 : rdata[VW-1:0];
	end

	// ------------------------------------------------------------------
	// shared slack unit
	tdh_pkg::slack_t sres;
	logic            usable;

	assign usable = rtree_q[ri_q] && !ctree_q[cj_q] && !e_inf;

	tdh_slack u_slack (
		.value    (e_val),
		.usable   (usable),
		.row_label(rl_q[ri_q]),
		.col_label(cl_q[cj_q]),
		.found    (found_q),
		.best     (best_q),
		.res      (sres)
	);

	// first unmatched row within the active size
	logic [IW-1:0] root_nxt;

	always_comb begin
		root_nxt = '0;
		for (int k = N - 1; k >= 0; k--) begin
			if ((CW'(k) < n_q) && (cor_q[k] == tdh_pkg::NONE_MARK)) begin
				root_nxt = IW'(k);
			end
		end
	end

	logic [IW-1:0] aug_row;
	logic [CW-1:0] aug_next;
	logic          cmax_take;
	logic signed [SW-1:0] best_nxt;
	logic          found_nxt;

	always_comb begin
		aug_row   = cpar_q[cj_q][IW-1:0];
		aug_next  = rpar_q[aug_row];
		cmax_take = !e_inf && (!found_q || (SW'(e_val) > best_q));
		best_nxt  = best_q;
		found_nxt = found_q;
		if (state_q == ST_CMAX_USE && cmax_take) begin
			best_nxt  = SW'(e_val);
			found_nxt = 1'b1;
		end else if (state_q == ST_SCAN_USE && sres.take) begin
			best_nxt  = sres.slack;
			found_nxt = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cfg_row_q   <= SIZE_MAX;
			cfg_col_q   <= SIZE_MAX;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: cfg_row_q <= cfg_data;
					REG_COLS: cfg_col_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept_in && s_tlast) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= (n_nxt == '0) ? ST_OUT : ST_CMAX_RD;
				end
				ST_CMAX_RD:  state_q <= ST_CMAX_USE;
				ST_CMAX_USE: begin
					if (!last_r) begin
						state_q <= ST_CMAX_RD;
					end else if (!found_nxt) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= last_c ? ST_PHASE : ST_CMAX_RD;
					end
				end
				ST_PHASE: begin
					state_q <= (matched_q == n_q) ? ST_SUM_RD : ST_SCAN_RD;
				end
				ST_SCAN_RD:  state_q <= ST_SCAN_USE;
				ST_SCAN_USE: begin
					if (sres.tight) begin
						state_q <= ST_GROW;
					end else if (last_r && last_c) begin
						state_q <= found_nxt ? ST_ADJ : ST_OUT;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_ADJ: begin
					if (last_r) begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_GROW: begin
					state_q <= (roc_q[cj_q] == tdh_pkg::NONE_MARK) ? ST_AUG : ST_SCAN_RD;
				end
				ST_AUG: begin
					if (aug_row == root_q || aug_next == tdh_pkg::NONE_MARK) begin
						state_q <= ST_PHASE;
					end
				end
				ST_SUM_RD:  state_q <= ST_SUM_USE;
				ST_SUM_USE: state_q <= last_c ? ST_OUT : ST_SUM_RD;
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// working registers
	always_ff @(posedge clk) begin
		best_q <= best_nxt;
		case (state_q)
			ST_SETUP: begin
				n_q       <= n_nxt;
				m_q       <= (r_eff > c_eff) ? c_eff : r_eff;
				trans_q   <= (r_eff > c_eff);
				ri_q      <= '0;
				cj_q      <= '0;
				found_q   <= 1'b0;
				matched_q <= '0;
				res_det_q <= '0;
				res_inf_q <= 1'b0;
				for (int k = 0; k < N; k++) begin
					rl_q[k]  <= '0;
					roc_q[k] <= tdh_pkg::NONE_MARK;
					cor_q[k] <= tdh_pkg::NONE_MARK;
				end
			end
			ST_CMAX_USE: begin
				ri_q    <= last_r ? '0 : ri_q + IW'(1);
				found_q <= last_r ? 1'b0 : found_nxt;
				if (last_r) begin
					cj_q <= cj_q + IW'(1);
					cl_q[cj_q] <= LW'(best_nxt);
					if (!found_nxt) begin
						res_inf_q <= 1'b1;
						res_det_q <= '0;
					end
				end
			end
			ST_PHASE: begin
				root_q  <= root_nxt;
				rtree_q <= {{(N-1){1'b0}}, 1'b1} << root_nxt;
				ctree_q <= '0;
				for (int k = 0; k < N; k++) begin
					rpar_q[k] <= tdh_pkg::NONE_MARK;
					cpar_q[k] <= tdh_pkg::NONE_MARK;
				end
				ri_q    <= '0;
				cj_q    <= '0;
				found_q <= 1'b0;
				sum_q   <= '0;
			end
			ST_SCAN_USE: begin
				found_q <= found_nxt;
				if (sres.tight) begin
					par_q <= ri_q;
				end else if (last_r && last_c) begin
					ri_q <= '0;
					cj_q <= '0;
					if (!found_nxt) begin
						res_inf_q <= 1'b1;
						res_det_q <= '0;
					end
				end else if (last_r) begin
					ri_q <= '0;
					cj_q <= cj_q + IW'(1);
				end else begin
					ri_q <= ri_q + IW'(1);
				end
			end
			ST_ADJ: begin
				// ri_q walks every row / column index once
				if (rtree_q[ri_q]) begin
					rl_q[ri_q] <= rl_q[ri_q] + LW'(best_q);
				end
				if (ctree_q[ri_q]) begin
					cl_q[ri_q] <= cl_q[ri_q] - LW'(best_q);
				end
				ri_q    <= last_r ? '0 : ri_q + IW'(1);
				found_q <= 1'b0;
			end
			ST_GROW: begin
				ctree_q[cj_q] <= 1'b1;
				cpar_q[cj_q]  <= {1'b0, par_q};
				if (roc_q[cj_q] != tdh_pkg::NONE_MARK) begin
					rtree_q[roc_q[cj_q][IW-1:0]] <= 1'b1;
					rpar_q[roc_q[cj_q][IW-1:0]]  <= {1'b0, cj_q};
					ri_q    <= '0;
					cj_q    <= '0;
					found_q <= 1'b0;
				end
			end
			ST_AUG: begin
				roc_q[cj_q]    <= {1'b0, aug_row};
				cor_q[aug_row] <= {1'b0, cj_q};
				if (aug_row == root_q || aug_next == tdh_pkg::NONE_MARK) begin
					matched_q <= matched_q + CW'(1);
				end else begin
					cj_q <= aug_next[IW-1:0];
				end
			end
			ST_SUM_RD: begin
				ri_q <= rd_row;
			end
			ST_SUM_USE: begin
				sum_q <= sum_q + DW'(e_val);
				cj_q  <= cj_q + IW'(1);
				if (last_c) begin
					res_det_q <= sum_q + DW'(e_val);
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_det_q <= res_det_q;
					out_inf_q <= res_inf_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_det_q};
	assign m_tuser  = out_inf_q;

	// ------------------------------------------------------------------
	`TDH_ASSERT_NEXT(a_last_starts, accept_in && s_tlast, state_q == ST_SETUP)
	`TDH_ASSERT_NOW(a_grow_new_col, state_q == ST_GROW, !ctree_q[cj_q])
	`TDH_ASSERT_NOW(a_matched_bound, state_q == ST_PHASE, matched_q <= n_q)
	`TDH_ASSERT_NEXT(a_result_shown, state_q == ST_OUT && (!out_valid_q || m_tready), m_tvalid)

endmodule
